/* rtl/u8d_pkg.sv */
// Shared types and constants of the UTF-8 to UTF-32 decoder.
// No dependencies; every other file of the block but u8d_checker refers to it by scoped names.

package u8d_pkg;

  // Codes of the invalid-byte policy register.
  localparam logic [1:0] POL_ABORT   = 2'd0;
  localparam logic [1:0] POL_ESCAPE  = 2'd1;
  localparam logic [1:0] POL_REPLACE = 2'd2;
  localparam logic [1:0] POL_RESET   = POL_ESCAPE;

  // Sequence length announced by a byte; NEED_NONE marks a byte that cannot start one.
  localparam logic [2:0] NEED_NONE = 3'd0;
  localparam logic [2:0] NEED_ONE  = 3'd1;
  localparam logic [2:0] NEED_TWO  = 3'd2;
  localparam logic [2:0] NEED_THREE = 3'd3;
  localparam logic [2:0] NEED_FOUR = 3'd4;

  localparam int unsigned WinDepth = 5;

  localparam logic [20:0] CP_ESCAPE_BASE = 21'h00DC80;
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

  // One byte with its classification.
  typedef struct packed {
    logic [7:0] data;
    logic       cont;
    logic [2:0] need;
  } u8d_class_t;

  // One queued request: a classified byte and its end-of-text mark.
  typedef struct packed {
    u8d_class_t cls;
    logic       eot;
  } u8d_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u8d_qstat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        substituted;
    logic        aborted;
    logic        run_last;
    logic        text_end;
  } u8d_res_t;

endpackage

/* rtl/u8d_front.sv */
// Input side of the decoder: takes byte requests and classifies each byte.
// Depends on u8d_pkg; feeds the request queue.

module u8d_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_text_i,
  input  u8d_pkg::u8d_qstat_t   qstat_i,
  output logic                  push_o,
  output u8d_pkg::u8d_item_t    item_o
);

  always_comb begin
    item_o.eot      = end_of_text_i;
    item_o.cls.data = data_byte_i;
    item_o.cls.cont = (data_byte_i[7:6] == 2'b10);
    priority if (data_byte_i[7] == 1'b0) begin
      item_o.cls.need = u8d_pkg::NEED_ONE;
    end else if (data_byte_i[7:5] == 3'b110) begin
      item_o.cls.need = u8d_pkg::NEED_TWO;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      item_o.cls.need = u8d_pkg::NEED_THREE;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      item_o.cls.need = u8d_pkg::NEED_FOUR;
    end else begin
      item_o.cls.need = u8d_pkg::NEED_NONE;
    end
  end

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

endmodule

/* rtl/u8d_queue.sv */
// Two-entry request queue between the classifying front and the decoding back.
// Depends on u8d_pkg for the request and status types.

module u8d_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u8d_pkg::u8d_item_t    item_i,
  input  logic                  pop_i,
  output u8d_pkg::u8d_item_t    item_o,
  output u8d_pkg::u8d_qstat_t   qstat_o
);

  u8d_pkg::u8d_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o        = slot_q[rd_ptr_q];
  assign qstat_o.full  = (fill_q == 2'd2);
  assign qstat_o.empty = (fill_q == 2'd0);

endmodule

/* rtl/u8d_back.sv */
// Decoding side: byte window, sequence judgment, policy register and result output.
// Depends on u8d_pkg; pops requests from u8d_queue.

module u8d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  u8d_pkg::u8d_qstat_t   qstat_i,
  input  u8d_pkg::u8d_item_t    item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u8d_pkg::u8d_res_t     res_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_JUDGE = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    V_WAIT,
    V_GOOD,
    V_BAD
  } verdict_e;

  state_e state_q, state_d;
  logic [1:0] policy_q;
  u8d_pkg::u8d_class_t win_q [u8d_pkg::WinDepth];
  u8d_pkg::u8d_class_t win_d [u8d_pkg::WinDepth];
  u8d_pkg::u8d_class_t win_shift [u8d_pkg::WinDepth];
  logic [2:0] cnt_q, cnt_d, cnt_shift;
  logic       fin_q, fin_d;
  logic       abort_q, abort_d;
  u8d_pkg::u8d_res_t pend_q, pend_d;
  logic       pend_valid_q, pend_valid_d;
  u8d_pkg::u8d_res_t out_q, out_d;
  logic       out_valid_q, out_valid_d;

  verdict_e    verdict;
  logic [20:0] cp_good;
  logic [2:0]  drop_len;
  logic        slot_free;

  // Judgment of the byte at the head of the window.
  always_comb begin
    u8d_pkg::u8d_class_t h;
    logic [2:0]  need;
    logic        cont_ok;
    logic        next_cont;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    h         = win_q[0];
    need      = h.need;
    cont_ok   = 1'b0;
    next_cont = 1'b0;
    v2 = {h.data[4:0], win_q[1].data[5:0]};
    v3 = {h.data[3:0], win_q[1].data[5:0], win_q[2].data[5:0]};
    v4 = {h.data[2:0], win_q[1].data[5:0], win_q[2].data[5:0], win_q[3].data[5:0]};
    verdict = V_BAD;
    cp_good = {13'd0, h.data};
    unique case (need)
      u8d_pkg::NEED_TWO: begin
        cont_ok   = win_q[1].cont;
        next_cont = win_q[2].cont;
      end
      u8d_pkg::NEED_THREE: begin
        cont_ok   = win_q[1].cont && win_q[2].cont;
        next_cont = win_q[3].cont;
      end
      u8d_pkg::NEED_FOUR: begin
        cont_ok   = win_q[1].cont && win_q[2].cont && win_q[3].cont;
        next_cont = win_q[4].cont;
      end
      default: begin
        cont_ok   = 1'b0;
        next_cont = 1'b0;
      end
    endcase
    priority if (need == u8d_pkg::NEED_ONE) begin
      verdict = V_GOOD;
    end else if (need == u8d_pkg::NEED_NONE) begin
      verdict = V_BAD;
    end else if (({1'b0, cnt_q} < ({1'b0, need} + 4'd1)) && !fin_q) begin
      verdict = V_WAIT;
    end else if (cnt_q < need) begin
      verdict = V_BAD;
    end else if (!cont_ok) begin
      verdict = V_BAD;
    end else if ((cnt_q > need) && next_cont) begin
      verdict = V_BAD;
    end else begin
      unique case (need)
        u8d_pkg::NEED_TWO: begin
          cp_good = {10'd0, v2};
          verdict = (v2 <= 11'd127) ? V_BAD : V_GOOD;
        end
        u8d_pkg::NEED_THREE: begin
          cp_good = {5'd0, v3};
          // Overlong forms and the surrogate range are both rejected.
          verdict = ((v3 <= 16'h07FF) || (v3 >= 16'hD800 && v3 <= 16'hDFFF)) ? V_BAD : V_GOOD;
        end
        default: begin
          cp_good = v4;
          verdict = (v4 <= 21'h00FFFF) ? V_BAD : V_GOOD;
        end
      endcase
    end
  end

  assign drop_len = (verdict == V_GOOD) ? win_q[0].need : u8d_pkg::NEED_ONE;

  // Window after the decided bytes leave the front.
  always_comb begin
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < u8d_pkg::WinDepth; i++) begin
      idx = 4'(i) + {1'b0, drop_len};
      win_shift[i] = win_q[i];
      if (idx < 4'(u8d_pkg::WinDepth)) begin
        win_shift[i] = win_q[idx[2:0]];
      end
    end
    cnt_shift = (drop_len >= cnt_q) ? 3'd0 : (cnt_q - drop_len);
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    win_d        = win_q;
    cnt_d        = cnt_q;
    fin_d        = fin_q;
    abort_d      = abort_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pop_o        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (abort_q) begin
            // Bytes after an abort are dropped up to the end of the text.
            if (item_i.eot) begin
              abort_d = 1'b0;
              cnt_d   = 3'd0;
            end
          end else begin
            win_d[cnt_q] = item_i.cls;
            cnt_d        = cnt_q + 3'd1;
            fin_d        = item_i.eot;
            state_d      = S_JUDGE;
          end
        end
      end
      S_JUDGE: begin
        if ((cnt_q != 3'd0) && (verdict != V_WAIT)) begin
          // The held result goes out only once the next one is known to exist.
          if (!pend_valid_q || slot_free) begin
            if (pend_valid_q) begin
              out_d          = pend_q;
              out_d.run_last = 1'b0;
              out_d.text_end = 1'b0;
              out_valid_d    = 1'b1;
            end
            pend_valid_d = 1'b1;
            pend_d.run_last = 1'b0;
            pend_d.text_end = 1'b0;
            pend_d.aborted  = 1'b0;
            if (verdict == V_GOOD) begin
              pend_d.code_point  = cp_good;
              pend_d.substituted = 1'b0;
              win_d = win_shift;
              cnt_d = cnt_shift;
            end else if (policy_q == u8d_pkg::POL_ABORT) begin
              pend_d.code_point  = 21'd0;
              pend_d.substituted = 1'b0;
              pend_d.aborted     = 1'b1;
              pend_d.text_end    = 1'b1;
              cnt_d   = 3'd0;
              abort_d = !fin_q;
            end else begin
              pend_d.code_point  = (policy_q == u8d_pkg::POL_ESCAPE) ?
                                   (u8d_pkg::CP_ESCAPE_BASE + {13'd0, win_q[0].data}) :
                                   u8d_pkg::CP_REPLACEMENT;
              pend_d.substituted = 1'b1;
              win_d = win_shift;
              cnt_d = cnt_shift;
            end
          end
        end else if (!pend_valid_q) begin
          state_d = S_IDLE;
          if (fin_q) begin
            cnt_d = 3'd0;
          end
        end else if (slot_free) begin
          out_d          = pend_q;
          out_d.run_last = 1'b1;
          out_d.text_end = pend_q.text_end || fin_q;
          out_valid_d    = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = S_IDLE;
          if (fin_q) begin
            cnt_d = 3'd0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      policy_q     <= u8d_pkg::POL_RESET;
      cnt_q        <= 3'd0;
      fin_q        <= 1'b0;
      abort_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      cnt_q        <= cnt_d;
      fin_q        <= fin_d;
      abort_q      <= abort_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

/* rtl/utf8_to_utf32_decoder.sv */
// UTF-8 to UTF-32 stream decoder, top level.
// Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.
//
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one byte of UTF-8 text per
// request, with end_of_text_i set on the last byte of a text. The output channel
// (out_valid_o / out_ready_i) carries decoded code points, substitutes for invalid
// bytes, or a single abort result, each with run_last_o and text_end_o marks.
// A byte request enters a two-entry queue and is classified on the way in; the
// decoding side pops one byte, then judges the head of its five-byte window once
// per cycle while the output is not stalled. Each result is held in a pending
// register until the next judgment or the closing step settles run_last_o, then
// passes to the output register. A popped byte goes through its judgments and a
// closing step before the next byte is popped. While the receiver stalls, the
// output register holds its result, the decoding side waits once a result is
// pending, and the queue takes up to two more bytes before in_ready_o drops.
// Reset empties the queue and the window, clears the abort state and sets the
// policy register to surrogate escape. cfg_we_i writes the policy from cfg_wdata_i
// and should only be used while the decoder is idle.

module utf8_to_utf32_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        substituted_o,
  output logic        aborted_o,
  output logic        run_last_o,
  output logic        text_end_o
);

  u8d_pkg::u8d_qstat_t qstat;
  u8d_pkg::u8d_item_t  push_item;
  u8d_pkg::u8d_item_t  pop_item;
  u8d_pkg::u8d_res_t   res;
  logic                push;
  logic                pop;

  u8d_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  u8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .qstat_o (qstat)
  );

  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qstat_i     (qstat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign code_point_o  = res.code_point;
  assign substituted_o = res.substituted;
  assign aborted_o     = res.aborted;
  assign run_last_o    = res.run_last;
  assign text_end_o    = res.text_end;

endmodule

/* rtl/u8d_checker.sv */
// Port-level checks of the UTF-8 decoder, bound to its top level.
// Depends only on the ports of utf8_to_utf32_decoder.

module u8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] code_point_o,
  input logic        substituted_o,
  input logic        aborted_o,
  input logic        run_last_o,
  input logic        text_end_o
);

  // An abort is the one and final result of its text, with a zero code point.
  a_abort_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && aborted_o) |-> (run_last_o && text_end_o && !substituted_o &&
                                    code_point_o == 21'd0))
    else $error("abort result not closing its text");

  // The end of a text is also the end of the results of its last byte.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_end_o) |-> run_last_o)
    else $error("text end without run last");

  // A substitute is either the replacement character or an escaped byte.
  a_subst_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && substituted_o) |-> (code_point_o == 21'h00FFFD ||
                                        (code_point_o >= 21'h00DC80 &&
                                         code_point_o <= 21'h00DD7F)))
    else $error("substitute value out of range");

  // A stalled result stays offered, with its code point and run_last mark unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(code_point_o) &&
                                       $stable(run_last_o)))
    else $error("stalled result changed");

endmodule

bind utf8_to_utf32_decoder u8d_checker u_u8d_checker (.*);

/* dv/utf8_to_utf32_decoder_test.sv */
// Testbench for utf8_to_utf32_decoder: byte requests in, code point results out, both
// with random idling, checked against a decoder model kept inside this file.
// Depends on u8d_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_test;

  // Unassigned policy code; the decoder treats it like replacement.
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned IdlePct = 24;

  typedef enum logic [1:0] {HEAD_WAIT, HEAD_DONE, HEAD_BAD} head_verdict_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [20:0] code_point_o;
  logic        substituted_o;
  logic        aborted_o;
  logic        run_last_o;
  logic        text_end_o;

  utf8_to_utf32_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .substituted_o (substituted_o),
    .aborted_o     (aborted_o),
    .run_last_o    (run_last_o),
    .text_end_o    (text_end_o)
  );

  // Decoder model state.
  logic [7:0]  win_bytes [u8d_pkg::WinDepth];
  int unsigned win_fill;
  bit          dropping;
  logic [1:0]  policy_model;

  u8d_pkg::u8d_res_t decoded_q [$];
  logic [7:0]  text_q [$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          calm;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic head_verdict_e judge_head(input bit fin, output logic [20:0] cp,
                                               output int unsigned len);
    logic [7:0]  b0;
    int unsigned need;
    b0 = win_bytes[0];
    cp = '0;
    len = 1;
    if (!b0[7]) begin
      cp = {13'd0, b0};
      return HEAD_DONE;
    end
    if (b0[7:5] == 3'b110) need = 2;
    else if (b0[7:4] == 4'b1110) need = 3;
    else if (b0[7:3] == 5'b11110) need = 4;
    else return HEAD_BAD;
    // A head waits for its whole sequence plus one byte of lookahead.
    if (win_fill < need + 1 && !fin) return HEAD_WAIT;
    if (win_fill < need) return HEAD_BAD;
    for (int i = 1; i < need; i++)
      if (!is_cont(win_bytes[i])) return HEAD_BAD;
    if (win_fill > need && is_cont(win_bytes[need])) return HEAD_BAD;
    case (need)
      2: begin
        cp = {10'd0, b0[4:0], win_bytes[1][5:0]};
        if (cp <= 21'h7F) return HEAD_BAD;
      end
      3: begin
        cp = {5'd0, b0[3:0], win_bytes[1][5:0], win_bytes[2][5:0]};
        if (cp <= 21'h7FF || (cp >= 21'hD800 && cp <= 21'hDFFF)) return HEAD_BAD;
      end
      default: begin
        cp = {b0[2:0], win_bytes[1][5:0], win_bytes[2][5:0], win_bytes[3][5:0]};
        if (cp <= 21'hFFFF) return HEAD_BAD;
      end
    endcase
    len = need;
    return HEAD_DONE;
  endfunction

  function automatic void drop_front(input int unsigned k);
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i + k < win_fill; i++) win_bytes[i] = win_bytes[i + k];
      win_fill = win_fill - k;
    end
  endfunction

  // Works out the results that one accepted byte causes and queues them.
  function automatic void decode_byte(input logic [7:0] b, input bit fin);
    u8d_pkg::u8d_res_t fresh [$];
    u8d_pkg::u8d_res_t res;
    logic [20:0]   cp;
    int unsigned   len;
    head_verdict_e verdict;
    bit            killed;
    killed = 1'b0;
    if (dropping) begin
      if (fin) begin
        dropping = 1'b0;
        win_fill = 0;
      end
      return;
    end
    if (win_fill >= u8d_pkg::WinDepth) win_fill = u8d_pkg::WinDepth - 1;
    win_bytes[win_fill] = b;
    win_fill++;
    while (win_fill > 0 && fresh.size() < u8d_pkg::WinDepth) begin
      verdict = judge_head(fin, cp, len);
      if (verdict == HEAD_WAIT) break;
      res = '0;
      if (verdict == HEAD_DONE) begin
        res.code_point = cp;
        fresh.push_back(res);
        drop_front(len);
      end else if (policy_model == u8d_pkg::POL_ABORT) begin
        res.aborted = 1'b1;
        res.run_last = 1'b1;
        res.text_end = 1'b1;
        fresh.push_back(res);
        killed = 1'b1;
        break;
      end else begin
        res.substituted = 1'b1;
        res.code_point = policy_model[1] ? u8d_pkg::CP_REPLACEMENT
                                         : u8d_pkg::CP_ESCAPE_BASE + {13'd0, win_bytes[0]};
        fresh.push_back(res);
        drop_front(1);
      end
    end
    if (killed) begin
      win_fill = 0;
      dropping = !fin;
    end else begin
      if (fin) win_fill = 0;
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].run_last = 1'b1;
        fresh[fresh.size() - 1].text_end = fin;
      end
    end
    foreach (fresh[i]) decoded_q.push_back(fresh[i]);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker: every accepted result is matched to the oldest expectation.
  always @(posedge clk_i) begin : result_check
    u8d_pkg::u8d_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: code_point %0h", code_point_o);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        // The code point of an abort result carries no meaning.
        if (!want.aborted) check_field("code_point", 32'(want.code_point),
                                       32'(code_point_o));
        check_field("substituted", 32'(want.substituted), 32'(substituted_o));
        check_field("aborted", 32'(want.aborted), 32'(aborted_o));
        check_field("run_last", 32'(want.run_last), 32'(run_last_o));
        check_field("text_end", 32'(want.text_end), 32'(text_end_o));
      end
    end
  end

  // Receiver: random stalls, a calm mode, and a counted hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte request and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input bit fin);
    int unsigned gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IdlePct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_byte_i <= b;
    end_of_text_i <= fin;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, fin);
  endtask

  task automatic send_text(input bit mark_end);
    foreach (text_q[i]) send_byte(text_q[i], mark_end && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    // Bytes that yield nothing may still be in flight.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_policy(input logic [1:0] value);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    policy_model = value;
  endtask

  function automatic void push_code_point(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: text_q.push_back({1'b0, cp[6:0]});
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_cp(input int unsigned len);
    logic [20:0] lo;
    logic [20:0] hi;
    case (len)
      1: begin lo = 21'h0;     hi = 21'h7F;     end
      2: begin lo = 21'h80;    hi = 21'h7FF;    end
      3: begin lo = 21'h800;   hi = 21'hFFFF;   end
      default: begin lo = 21'h10000; hi = 21'h1FFFFF; end
    endcase
    if ($urandom_range(9) == 0) return $urandom_range(1) ? lo : hi;
    return 21'($urandom_range(hi, lo));
  endfunction

  // Appends one character: a well-formed encoding, or one of the broken forms.
  function automatic void add_char(input bit broken);
    int unsigned len;
    len = $urandom_range(4, 2);
    if (!broken) begin
      len = $urandom_range(4, 1);
      push_code_point(pick_cp(len), len);
    end else begin
      case ($urandom_range(5))
        0: text_q.push_back(8'($urandom_range(255)));
        1: push_code_point(21'(len == 2 ? $urandom_range(8'h7F)
                             : len == 3 ? $urandom_range(11'h7FF)
                                        : $urandom_range(16'hFFFF)), len);
        2: begin
          push_code_point(pick_cp(len), len);
          void'(text_q.pop_back());
        end
        3: push_code_point(21'($urandom_range(16'hDFFF, 16'hD800)), 3);
        4: begin
          push_code_point(pick_cp(len), len);
          text_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
        default: begin
          repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
      endcase
    end
  endfunction

  // Random texts until about n_items bytes have been decoded; dropped bytes do not count.
  task automatic send_random(input int unsigned n_items, input int unsigned broken_pct);
    int unsigned counted;
    bit          mark;
    counted = 0;
    while (counted < n_items) begin
      text_q.delete();
      repeat ($urandom_range(8, 1)) add_char($urandom_range(99) < broken_pct);
      mark = ($urandom_range(99) < 85) || (counted + text_q.size() >= n_items);
      foreach (text_q[i]) begin
        if (!dropping) counted++;
        send_byte(text_q[i], mark && (i == text_q.size() - 1));
      end
    end
    text_q.delete();
  endtask

  // Reset policy: four-byte form above U+10FFFF, ASCII extremes, overlong form,
  // surrogate, stray continuation, an impossible head byte, a trailing continuation,
  // and a sequence cut short by the end of text.
  task automatic test_escape_directed();
    text_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h7F, 8'hC0, 8'h80, 8'hED, 8'hA0,
               8'h80, 8'hFF, 8'hC3, 8'hA9, 8'h80, 8'hE2, 8'h82};
    send_text(1'b1);
  endtask

  task automatic test_replace_directed();
    set_policy(u8d_pkg::POL_REPLACE);
    text_q = '{8'hC3, 8'h41};
    send_text(1'b1);
    set_policy(POL_SPARE);
    text_q = '{8'hF8};
    send_text(1'b1);
  endtask

  // Abort drops the rest of the text; the next text decodes normally.
  task automatic test_abort_directed();
    set_policy(u8d_pkg::POL_ABORT);
    text_q = '{8'h41, 8'h80, 8'hC3, 8'hA9};
    send_text(1'b1);
    text_q = '{8'hF0, 8'h90, 8'h80, 8'h80};
    send_text(1'b1);
  endtask

  task automatic test_random_escape();
    set_policy(u8d_pkg::POL_ESCAPE);
    send_random(85, 30);
  endtask

  task automatic test_random_replace_calm();
    set_policy(u8d_pkg::POL_REPLACE);
    calm = 1'b1;
    send_random(55, 30);
    wait_quiet();
    calm = 1'b0;
  endtask

  task automatic test_random_abort();
    set_policy(u8d_pkg::POL_ABORT);
    send_random(55, 8);
  endtask

  // The receiver holds off long enough for the input to stall, and later the sender
  // pauses until all results are in.
  task automatic test_backpressure();
    set_policy(POL_SPARE);
    send_random(15, 25);
    hold_left = 120;
    send_random(30, 25);
    wait_quiet();
    send_random(25, 25);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = u8d_pkg::POL_RESET;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    end_of_text_i = 1'b0;
    out_ready_i = 1'b0;
    win_fill = 0;
    dropping = 1'b0;
    policy_model = u8d_pkg::POL_RESET;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_left = 0;
    calm = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_escape_directed();
    test_replace_directed();
    test_abort_directed();
    test_random_escape();
    test_random_replace_calm();
    test_random_abort();
    test_backpressure();

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
